// ----- hw/rtl/p2s_pkg.sv -----
// p2s_pkg: widths, codes and shared types for the position-to-section lookup.
// No dependencies; compiled first.
package p2s_pkg;

   localparam int MAX_SECTIONS = 4096;
   localparam int IDX_W        = $clog2(MAX_SECTIONS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int POS_BITS     = 24;
   localparam int POSN_W       = 26;
   localparam int OP_W         = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 24;
   localparam int PROBE_W      = IDX_W + POS_BITS + 1;
   localparam int DIVD_W       = POSN_W;
   localparam int DIV_CNT_W    = $clog2(DIVD_W);

   localparam logic [POS_BITS-1:0] PROBE_OFFSET = POS_BITS'(100);

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT     = 2'd2;

   localparam logic [POS_BITS-1:0] TRACK_LEN_RST = POS_BITS'(1000000);
   localparam logic [POS_BITS-1:0] MEAN_LEN_RST  = POS_BITS'(1000);
   localparam logic [CNT_W-1:0]    COUNT_RST     = CNT_W'(1000);

   // datapath command, one per cycle
   typedef enum logic [4:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_LOAD_WR,
      DP_DIV_WRAP,
      DP_SET_POS,
      DP_DIV_BUCKET,
      DP_SET_Q,
      DP_DIV_MODQ,
      DP_HINT_RD,
      DP_HINT_IDX,
      DP_DIV_K,
      DP_SET_EST,
      DP_EST_IDX,
      DP_RD_CUR,
      DP_RD_NEXT,
      DP_DEC,
      DP_INC,
      DP_SET_LAST,
      DP_HINT_WR,
      DP_NEXT_BUCKET,
      DP_RSP
   } dp_op_type;

   typedef struct packed {
      logic div_done;
      logic is_lookup;
      logic cmp_lt;
      logic cmp_gt;
      logic idx_zero;
      logic idx_p1_lt;
      logic idx_p2_lt;
      logic last_bucket;
   } p2s_stat_type;

endpackage

// ----- hw/rtl/p2s_ifs.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on p2s_pkg.
interface p2s_req_if import p2s_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [IDX_W-1:0]         entry_index;
   logic [POS_BITS-1:0]      start_distance;
   logic signed [POSN_W-1:0] position;

   modport source (output valid, op, entry_index, start_distance, position, input ready);
   modport sink   (input valid, op, entry_index, start_distance, position, output ready);
endinterface

interface p2s_rsp_if import p2s_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] section_index;
   logic             status;

   modport source (output valid, section_index, status, input ready);
   modport sink   (input valid, section_index, status, output ready);
endinterface

// ----- hw/rtl/p2s_ram.sv -----
// p2s_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module p2s_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/p2s_div.sv -----
// p2s_div: restoring divider, one quotient bit per cycle.
// Depends on p2s_pkg.
module p2s_div import p2s_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIVD_W-1:0]   dividend,
   input  logic [POS_BITS-1:0] divisor,
   output logic [DIVD_W-1:0]   quot,
   output logic [POS_BITS-1:0] rem,
   output logic                done
);

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVD_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [DIVD_W-1:0]   quot_ff, quot_in;
   logic [POS_BITS-1:0] rem_ff, rem_in;
   logic [POS_BITS-1:0] dsr_ff, dsr_in;
   logic [POS_BITS:0]   shifted;
   logic [POS_BITS:0]   trial;

   always_comb begin
      shifted = {rem_ff, quot_ff[DIVD_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in  = trial[POS_BITS-1:0];
            quot_in = {quot_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[POS_BITS-1:0];
            quot_in = {quot_ff[DIVD_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

// ----- hw/rtl/p2s_dpath.sv -----
// p2s_dpath: config registers, section/hint RAMs, divider and walk registers.
// Depends on p2s_pkg, p2s_ram, p2s_div.
module p2s_dpath import p2s_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_op_type                dp_op,
   output p2s_stat_type             stat,
   input  logic [OP_W-1:0]          req_op,
   input  logic [IDX_W-1:0]         req_entry_index,
   input  logic [POS_BITS-1:0]      req_start_distance,
   input  logic signed [POSN_W-1:0] req_position,
   output logic [IDX_W-1:0]         rsp_section_index,
   output logic                     rsp_status,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wr_data
);

   logic [POS_BITS-1:0] track_len_ff, mean_len_ff;
   logic [CNT_W-1:0]    count_ff;

   logic [OP_W-1:0]          op_ff;
   logic [IDX_W-1:0]         entry_ff;
   logic [POS_BITS-1:0]      sdist_ff;
   logic signed [POSN_W-1:0] posn_ff;
   logic [POS_BITS-1:0]      pos_ff, pos_in;
   logic [POS_BITS-1:0]      q_ff;
   logic [IDX_W-1:0]         est_ff, b_ff, idx_ff;
   logic [PROBE_W-1:0]       probe_ff;
   logic                     status_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic                     rsp_status_ff;

   logic [CNT_W-1:0]    cnt;
   logic [POS_BITS-1:0] len, mean;
   logic [CNT_W-1:0]    cnt_m1;
   logic                in_range;

   logic                div_start;
   logic [DIVD_W-1:0]   div_dividend;
   logic [POS_BITS-1:0] div_divisor;
   logic [DIVD_W-1:0]   div_quot;
   logic [POS_BITS-1:0] div_rem;
   logic                div_done;

   logic [POS_BITS-1:0] start_rd;
   logic [IDX_W-1:0]    hint_rd;
   logic [IDX_W-1:0]    start_rd_addr;
   logic [PROBE_W-1:0]  walk_val;
   logic [PROBE_W-1:0]  start_ext;
   logic [CNT_W-1:0]    est_p1;

   // effective config: clamp count, zero lengths act as one
   always_comb begin
      if (count_ff < CNT_W'(2)) begin
         cnt = CNT_W'(2);
      end else if (count_ff > CNT_W'(MAX_SECTIONS)) begin
         cnt = CNT_W'(MAX_SECTIONS);
      end else begin
         cnt = count_ff;
      end
      len    = (track_len_ff == '0) ? POS_BITS'(1) : track_len_ff;
      mean   = (mean_len_ff == '0) ? POS_BITS'(1) : mean_len_ff;
      cnt_m1 = cnt - 1'b1;
   end

   assign in_range = ({1'b0, entry_ff} < cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         track_len_ff <= TRACK_LEN_RST;
         mean_len_ff  <= MEAN_LEN_RST;
         count_ff     <= COUNT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRACK_LEN: track_len_ff <= csr_wr_data;
            CSR_MEAN_LEN:  mean_len_ff  <= csr_wr_data;
            CSR_COUNT:     count_ff     <= csr_wr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // divider operand select
   always_comb begin
      div_start    = 1'b1;
      div_dividend = '0;
      div_divisor  = POS_BITS'(1);
      unique case (dp_op)
         DP_DIV_WRAP: begin
            div_dividend = posn_ff[POSN_W-1] ? DIVD_W'(-posn_ff) : DIVD_W'(posn_ff);
            div_divisor  = len;
         end
         DP_DIV_BUCKET: begin
            div_dividend = DIVD_W'(pos_ff);
            div_divisor  = mean;
         end
         DP_DIV_MODQ: begin
            div_dividend = DIVD_W'(q_ff);
            div_divisor  = POS_BITS'(cnt);
         end
         DP_DIV_K: begin
            div_dividend = DIVD_W'(PROBE_OFFSET);
            div_divisor  = mean;
         end
         default: div_start = 1'b0;
      endcase
   end

   p2s_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quot     (div_quot),
      .rem      (div_rem),
      .done     (div_done)
   );

   // true modulo: a negative operand with nonzero remainder folds up
   always_comb begin
      if (posn_ff[POSN_W-1] && (div_rem != '0)) begin
         pos_in = len - div_rem;
      end else begin
         pos_in = div_rem;
      end
   end

   assign start_rd_addr = (dp_op == DP_RD_NEXT) ? idx_ff + 1'b1 : idx_ff;

   p2s_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_SECTIONS)) u_start_ram (
      .clock   (clock),
      .wr_en   ((dp_op == DP_LOAD_WR) && in_range),
      .wr_addr (entry_ff),
      .wr_data (sdist_ff),
      .rd_en   ((dp_op == DP_RD_CUR) || (dp_op == DP_RD_NEXT)),
      .rd_addr (start_rd_addr),
      .rd_data (start_rd)
   );

   p2s_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SECTIONS)) u_hint_ram (
      .clock   (clock),
      .wr_en   (dp_op == DP_HINT_WR),
      .wr_addr (b_ff),
      .wr_data (idx_ff),
      .rd_en   (dp_op == DP_HINT_RD),
      .rd_addr (div_rem[IDX_W-1:0]),
      .rd_data (hint_rd)
   );

   assign walk_val  = (op_ff == OP_LOOKUP) ? PROBE_W'(pos_ff) : probe_ff;
   assign start_ext = PROBE_W'(start_rd);
   assign est_p1    = {1'b0, est_ff} + 1'b1;

   always_ff @(posedge clock) begin
      unique case (dp_op)
         DP_CAPTURE: begin
            op_ff     <= req_op;
            entry_ff  <= req_entry_index;
            sdist_ff  <= req_start_distance;
            posn_ff   <= req_position;
            status_ff <= 1'b0;
         end
         DP_LOAD_WR:  status_ff <= !in_range;
         DP_SET_POS:  pos_ff <= pos_in;
         DP_SET_Q:    q_ff   <= div_quot[POS_BITS-1:0];
         DP_HINT_IDX: idx_ff <= ({1'b0, hint_rd} >= cnt) ? cnt_m1[IDX_W-1:0] : hint_rd;
         DP_SET_EST: begin
            est_ff   <= div_rem[IDX_W-1:0];
            b_ff     <= '0;
            probe_ff <= PROBE_W'(PROBE_OFFSET);
         end
         DP_EST_IDX:  idx_ff <= est_ff;
         DP_DEC:      idx_ff <= idx_ff - 1'b1;
         DP_INC:      idx_ff <= idx_ff + 1'b1;
         DP_SET_LAST: idx_ff <= cnt_m1[IDX_W-1:0];
         DP_NEXT_BUCKET: begin
            b_ff     <= b_ff + 1'b1;
            probe_ff <= probe_ff + PROBE_W'(mean);
            est_ff   <= (est_p1 == cnt) ? '0 : est_p1[IDX_W-1:0];
         end
         DP_RSP: begin
            rsp_index_ff  <= (op_ff == OP_LOOKUP) ? idx_ff : '0;
            rsp_status_ff <= status_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.div_done    = div_done;
      stat.is_lookup   = (op_ff == OP_LOOKUP);
      stat.cmp_lt      = walk_val < start_ext;
      stat.cmp_gt      = walk_val > start_ext;
      stat.idx_zero    = (idx_ff == '0);
      stat.idx_p1_lt   = ({1'b0, idx_ff} + CNT_W'(1)) < cnt;
      stat.idx_p2_lt   = ({2'b0, idx_ff} + (CNT_W+1)'(2)) < {1'b0, cnt};
      stat.last_bucket = ({1'b0, b_ff} + CNT_W'(1)) == cnt;
   end

   assign rsp_section_index = rsp_index_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ----- hw/rtl/p2s_ctrl.sv -----
// p2s_ctrl: sequencer for load, hint build and lookup; owns the handshakes.
// Depends on p2s_pkg.
module p2s_ctrl import p2s_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_op,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  p2s_stat_type    stat,
   output dp_op_type       dp_op
);

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_WRAP, S_WRAP_W, S_BUCK, S_BUCK_W, S_MODQ, S_MODQ_W,
      S_HINT, S_K, S_K_W, S_BUCKET, S_BACK_RD, S_BACK_CMP, S_FWD, S_FWD_CMP,
      S_END, S_NEXT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      dp_op        = DP_NOP;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_op = DP_CAPTURE;
               priority case (req_op)
                  OP_LOAD:   state_in = S_LOAD;
                  OP_BUILD:  state_in = S_K;
                  OP_LOOKUP: state_in = S_WRAP;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_LOAD: begin
            dp_op    = DP_LOAD_WR;
            state_in = S_DONE;
         end
         S_WRAP: begin
            dp_op    = DP_DIV_WRAP;
            state_in = S_WRAP_W;
         end
         S_WRAP_W: begin
            if (stat.div_done) begin
               dp_op    = DP_SET_POS;
               state_in = S_BUCK;
            end
         end
         S_BUCK: begin
            dp_op    = DP_DIV_BUCKET;
            state_in = S_BUCK_W;
         end
         S_BUCK_W: begin
            if (stat.div_done) begin
               dp_op    = DP_SET_Q;
               state_in = S_MODQ;
            end
         end
         S_K: begin
            dp_op    = DP_DIV_K;
            state_in = S_K_W;
         end
         S_K_W: begin
            if (stat.div_done) begin
               dp_op    = DP_SET_Q;
               state_in = S_MODQ;
            end
         end
         S_MODQ: begin
            dp_op    = DP_DIV_MODQ;
            state_in = S_MODQ_W;
         end
         S_MODQ_W: begin
            if (stat.div_done) begin
               if (stat.is_lookup) begin
                  dp_op    = DP_HINT_RD;
                  state_in = S_HINT;
               end else begin
                  dp_op    = DP_SET_EST;
                  state_in = S_BUCKET;
               end
            end
         end
         S_HINT: begin
            dp_op    = DP_HINT_IDX;
            state_in = S_BACK_RD;
         end
         S_BUCKET: begin
            dp_op    = DP_EST_IDX;
            state_in = S_BACK_RD;
         end
         S_BACK_RD: begin
            dp_op    = DP_RD_CUR;
            state_in = S_BACK_CMP;
         end
         S_BACK_CMP: begin
            if (stat.cmp_lt && !stat.idx_zero) begin
               dp_op    = DP_DEC;
               state_in = S_BACK_RD;
            end else if (stat.cmp_lt && stat.is_lookup) begin
               // lookup below the first start answers section zero
               state_in = S_END;
            end else begin
               state_in = S_FWD;
            end
         end
         S_FWD: begin
            // in a build the forward step never reads the last section
            if (stat.is_lookup ? stat.idx_p1_lt : stat.idx_p2_lt) begin
               dp_op    = DP_RD_NEXT;
               state_in = S_FWD_CMP;
            end else begin
               state_in = S_END;
            end
         end
         S_FWD_CMP: begin
            if (!stat.cmp_gt) begin
               state_in = S_END;
            end else if (stat.idx_p2_lt) begin
               dp_op    = DP_INC;
               state_in = S_FWD;
            end else begin
               dp_op    = DP_SET_LAST;
               state_in = S_END;
            end
         end
         S_END: begin
            if (stat.is_lookup) begin
               state_in = S_DONE;
            end else begin
               dp_op    = DP_HINT_WR;
               state_in = stat.last_bucket ? S_DONE : S_NEXT;
            end
         end
         S_NEXT: begin
            dp_op    = DP_NEXT_BUCKET;
            state_in = S_BUCKET;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_op        = DP_RSP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/position_to_section_lookup.sv -----
// Top level of the position-to-section lookup: controller plus datapath.
// Depends on p2s_pkg, p2s_ifs, p2s_ctrl, p2s_dpath.
//
//   channel   direction  beat contents
//   req_bus   in         op, entry_index, start_distance, position
//   rsp_bus   out        section_index, status
//   csr_*     in         wr_en, index, wr_data (24 bit)
//
// One item at a time. Load writes one start entry. Lookup runs three divisions in
// the shared bit-serial divider, reads the hint, then steps section by section.
// Build runs its setup divisions, then walks and writes one hint per bucket.
// Reset clears control and config only; the RAMs are not cleared.
// A result waiting in the output register does not block the next request beat.
module position_to_section_lookup import p2s_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   p2s_req_if.sink               req_bus,
   p2s_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   dp_op_type    dp_op;
   p2s_stat_type stat;

   p2s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_op    (req_bus.op),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .dp_op     (dp_op)
   );

   p2s_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .dp_op              (dp_op),
      .stat               (stat),
      .req_op             (req_bus.op),
      .req_entry_index    (req_bus.entry_index),
      .req_start_distance (req_bus.start_distance),
      .req_position       (req_bus.position),
      .rsp_section_index  (rsp_bus.section_index),
      .rsp_status         (rsp_bus.status),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

endmodule

// ----- hw/rtl/p2s_checker.sv -----
// p2s_checker: port-level assertions for the lookup block, bound to the top.
// Depends on p2s_pkg.
module p2s_checker import p2s_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [IDX_W-1:0] rsp_section_index,
   input logic             rsp_status
);

   // a stalled response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_section_index)
         && $stable(rsp_status))
      else $error("response payload changed while stalled");

   // one item in flight: no second request right after an accepted one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a rejected load answers section zero
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_section_index == '0)
      else $error("status set with nonzero section");

   // a new result only comes out of a busy cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without a request in flight");

endmodule

bind position_to_section_lookup p2s_checker u_p2s_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_section_index (rsp_bus.section_index),
   .rsp_status        (rsp_bus.status)
);

// ----- dv/tb_position_to_section_lookup.sv -----
// Testbench for position_to_section_lookup: a queued driver, a response monitor
// and a behavioral predictor of the section table, the hint table and the lookup.
// Depends on p2s_pkg, p2s_ifs and position_to_section_lookup.
`timescale 1ns / 100ps

module tb_position_to_section_lookup;
   import p2s_pkg::*;

   localparam int LIMIT_CYCLES = 3_000_000;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic [IDX_W-1:0]         entry;
      logic [POS_BITS-1:0]      start_mm;
      logic signed [POSN_W-1:0] posn;
   } req_beat_t;

   typedef struct {
      logic [IDX_W-1:0] section;
      logic             status;
   } rsp_beat_t;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_TRACK_LEN;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   p2s_req_if req_bus ();
   p2s_rsp_if rsp_bus ();

   position_to_section_lookup DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   req_beat_t pending_q[$];
   rsp_beat_t section_q[$];
   int        cycles = 0;
   bit        failed = 1'b0;

   // shadow state
   logic [POS_BITS-1:0] start_tab [MAX_SECTIONS];
   logic [IDX_W-1:0]    hint_tab  [MAX_SECTIONS];
   logic [POS_BITS-1:0] loop_len  = TRACK_LEN_RST;
   logic [POS_BITS-1:0] bucket_len = MEAN_LEN_RST;
   logic [CNT_W-1:0]    sec_count = COUNT_RST;

   function automatic int unsigned used_count();
      int unsigned c;
      c = sec_count;
      if (c < 2) c = 2;
      if (c > MAX_SECTIONS) c = MAX_SECTIONS;
      return c;
   endfunction

   function automatic longint unsigned bucket_mm();
      return (bucket_len == 0) ? 1 : longint'(bucket_len);
   endfunction

   function automatic void fill_hints();
      int unsigned      cnt;
      longint unsigned  m;
      longint unsigned  probe;
      int unsigned      idx;
      cnt = used_count();
      m   = bucket_mm();
      for (int unsigned b = 0; b < cnt; b++) begin
         probe = longint'(b) * m + 100;
         idx = 32'((probe / m) % cnt);
         while (probe < start_tab[idx] && idx > 0) idx--;
         while (idx + 2 < cnt && probe > start_tab[idx + 1]) idx++;
         hint_tab[b] = IDX_W'(idx);
      end
   endfunction

   function automatic int unsigned find_section(logic signed [POSN_W-1:0] p);
      int unsigned     cnt;
      longint unsigned m;
      longint          len;
      longint          r;
      longint unsigned pos;
      int unsigned     idx;
      cnt = used_count();
      m   = bucket_mm();
      len = (loop_len == 0) ? 1 : longint'(loop_len);
      r = longint'(p) % len;
      if (r < 0) r += len;
      pos = r;
      idx = hint_tab[(pos / m) % cnt];
      if (idx >= cnt) idx = cnt - 1;
      while (pos < start_tab[idx]) begin
         if (idx > 0) idx--;
         else return 0;
      end
      forever begin
         if (idx + 1 >= cnt) break;
         if (!(pos > start_tab[idx + 1])) break;
         if (idx + 2 < cnt) idx++;
         else return cnt - 1;
      end
      return idx;
   endfunction

   function automatic rsp_beat_t predict(req_beat_t it);
      rsp_beat_t e;
      e.section = '0;
      e.status  = 1'b0;
      case (it.op)
         OP_LOAD: begin
            if (it.entry < used_count()) start_tab[it.entry] = it.start_mm;
            else e.status = 1'b1;
         end
         OP_BUILD: fill_hints();
         OP_LOOKUP: e.section = IDX_W'(find_section(it.posn));
         default: ;
      endcase
      return e;
   endfunction

   // idle about 24% of cycles, except in a quiet window
   function automatic bit take_gap();
      if ((cycles % 40000) < 6000) return 1'b0;
      return $urandom_range(0, 99) < 24;
   endfunction

   // request driver
   always @(posedge clock) begin
      req_beat_t nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) section_q.push_back(predict('{req_bus.op, req_bus.entry_index,
                                                         req_bus.start_distance,
                                                         req_bus.position}));
         if (pending_q.size() > 0 && !take_gap()) begin
            nxt = pending_q.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.op             <= nxt.op;
            req_bus.entry_index    <= nxt.entry;
            req_bus.start_distance <= nxt.start_mm;
            req_bus.position       <= nxt.posn;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor and sink stalls
   always @(posedge clock) begin
      rsp_beat_t e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !take_gap();
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (section_q.size() == 0) begin
               $error("unexpected response beat: section_index %0d status %0d",
                      rsp_bus.section_index, rsp_bus.status);
               failed = 1'b1;
            end else begin
               e = section_q.pop_front();
               if (rsp_bus.section_index !== e.section) begin
                  $error("section_index: expected %0d, actual %0d",
                         e.section, rsp_bus.section_index);
                  failed = 1'b1;
               end
               if (rsp_bus.status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_bus.status);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.op             = OP_LOAD;
      req_bus.entry_index    = '0;
      req_bus.start_distance = '0;
      req_bus.position       = '0;
      rsp_bus.ready          = 1'b0;
   end

   task automatic push_beat(logic [OP_W-1:0] op, int unsigned entry,
                            logic [POS_BITS-1:0] start_mm, logic signed [POSN_W-1:0] posn);
      req_beat_t it;
      it.op       = op;
      it.entry    = IDX_W'(entry);
      it.start_mm = start_mm;
      it.posn     = posn;
      pending_q.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_bus.valid || section_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_TRACK_LEN: loop_len   = val;
         CSR_MEAN_LEN:  bucket_len = val;
         CSR_COUNT:     sec_count  = CNT_W'(val);
         default: ;
      endcase
   endtask

   function automatic logic [POS_BITS-1:0] spaced(int unsigned i, int unsigned jit);
      longint unsigned d;
      d = longint'(i) * bucket_mm() + jit;
      return (d > 24'hFFFFFF) ? 24'hFFFFFF : POS_BITS'(d);
   endfunction

   // configure, fill every entry in use, build hints, then random beats
   task automatic run_phase(int unsigned len, int unsigned mean, int unsigned cnt_raw,
                            bit sorted, int nrand);
      int unsigned cnt;
      int unsigned r;
      int unsigned e;
      logic [POS_BITS-1:0] d;
      logic signed [POSN_W-1:0] p;
      csr_write(CSR_TRACK_LEN, CSR_DATA_W'(len));
      csr_write(CSR_MEAN_LEN, CSR_DATA_W'(mean));
      csr_write(CSR_COUNT, CSR_DATA_W'(cnt_raw));
      cnt = used_count();
      for (int unsigned i = 0; i < cnt; i++) begin
         d = sorted ? spaced(i, $urandom_range(0, 3)) : POS_BITS'($urandom);
         push_beat(OP_LOAD, i, d, '0);
      end
      push_beat(OP_BUILD, 0, '0, '0);
      for (int k = 0; k < nrand; k++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            if ($urandom_range(0, 1)) p = POSN_W'($urandom);
            else p = POSN_W'(longint'($urandom_range(0, 2 * len + 2)) - len);
            push_beat(OP_LOOKUP, 0, POS_BITS'($urandom), p);
         end else if (r < 78) begin
            e = $urandom_range(0, 9) < 7 ? $urandom_range(0, cnt - 1) : $urandom_range(0, 4095);
            d = $urandom_range(0, 1) ? spaced(e, $urandom_range(0, 200)) : POS_BITS'($urandom);
            push_beat(OP_LOAD, e, d, POSN_W'($urandom));
         end else if (r < 86 && cnt <= 256) begin
            push_beat(OP_BUILD, $urandom, POS_BITS'($urandom), POSN_W'($urandom));
         end else if (r < 90) begin
            push_beat(OP_UNUSED, $urandom, POS_BITS'($urandom), POSN_W'($urandom));
         end else begin
            // right on a section boundary, or one mm either side
            e = $urandom_range(0, cnt - 1);
            p = POSN_W'(longint'(start_tab[e]) + $urandom_range(0, 2) - 1);
            push_beat(OP_LOOKUP, 0, '0, p);
         end
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         start_tab[i] = '0;
         hint_tab[i]  = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small sorted table of ten sections
      csr_write(CSR_TRACK_LEN, 24'd1000);
      csr_write(CSR_MEAN_LEN, 24'd100);
      csr_write(CSR_COUNT, 24'd10);
      for (int i = 0; i < 10; i++) push_beat(OP_LOAD, i, POS_BITS'(i * 100), '0);
      push_beat(OP_LOAD, 10, 24'd5, '0);           // index at count: ignored
      push_beat(OP_LOAD, 4095, 24'hFFFFFF, '1);    // top index: ignored
      push_beat(OP_BUILD, 0, '0, '0);
      push_beat(OP_LOOKUP, 0, '0, 26'sd0);
      push_beat(OP_LOOKUP, 0, '0, -26'sd1);
      push_beat(OP_LOOKUP, 0, '0, 26'sd100);       // exactly on a start
      push_beat(OP_LOOKUP, 0, '0, 26'sd999);
      push_beat(OP_LOOKUP, 0, '0, 26'sd1000);      // wraps to zero
      push_beat(OP_LOOKUP, 0, '0, 26'h2000000);    // most negative
      push_beat(OP_LOOKUP, 0, '0, 26'h1FFFFFF);    // most positive
      push_beat(OP_LOOKUP, 0, '0, 26'sd950);       // inside the last section
      push_beat(OP_UNUSED, 4095, 24'hFFFFFF, '1);
      push_beat(OP_LOAD, 9, 24'hFFFFFF, '0);       // last section out of order
      push_beat(OP_LOOKUP, 0, '0, 26'sd990);
      push_beat(OP_LOAD, 0, 24'd500, '0);          // first start above the query
      push_beat(OP_LOOKUP, 0, '0, 26'sd50);
      wait_drained();

      // register extremes: zero, maximum and unit lengths, and a zero count
      run_phase(0, 0, 0, 1'b1, 30);
      run_phase(16777215, 16777215, 3, 1'b1, 30);
      run_phase(1, 1, 2, 1'b0, 30);

      // count beyond the maximum acts as the maximum: top indexes are taken
      csr_write(CSR_COUNT, 24'd8191);
      for (int i = 0; i < 8; i++)
         push_beat(OP_LOAD, 4088 + i, POS_BITS'($urandom), '0);
      for (int i = 0; i < 12; i++)
         push_beat(OP_LOAD, $urandom_range(0, 4095), POS_BITS'($urandom), '0);
      wait_drained();

      for (int ph = 0; ph < 5; ph++)
         run_phase($urandom_range(1, 24'hFFFFFF), $urandom_range(1, 5000),
                   $urandom_range(2, 24), $urandom_range(0, 3) != 0, 25);
      run_phase(1000000, 1000, 40, 1'b1, 20);

      repeat (50) @(posedge clock);
      if (!failed && section_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- position_to_section_lookup.f -----
hw/rtl/p2s_pkg.sv
hw/rtl/p2s_ifs.sv
hw/rtl/p2s_ram.sv
hw/rtl/p2s_div.sv
hw/rtl/p2s_dpath.sv
hw/rtl/p2s_ctrl.sv
hw/rtl/position_to_section_lookup.sv
hw/rtl/p2s_checker.sv
dv/tb_position_to_section_lookup.sv
